// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the keypad debouncer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- rtl/core/kdd_pkg.sv -----
// ----------------------------------------------------------------------------
// kdd_pkg
// Types, widths and constant tables for the keypad decode and debounce block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kdd_pkg;

  localparam int TIME_W  = 32;
  localparam int ADC_W   = 10;
  localparam int SHIFT_W = 16;
  localparam int KEY_W   = 4;
  localparam int DBM_W   = 16;

  // Shift-register bytes scanned; bytes past the 16-bit field read as zero.
  localparam int SHIFT_IN_BYTES = 2;

  localparam logic [DBM_W-1:0] DEBOUNCE_RESET = 16'd50;

  // Ladder keypad windows [lo, hi): floor(V*1024/5.14) at V -/+ 0.05.
  localparam int NUM_WIN = 12;
  localparam logic [ADC_W-1:0] WIN_LO [NUM_WIN] = '{
    10'd193, 10'd233, 10'd280, 10'd330, 10'd392, 10'd472,
    10'd549, 10'd609, 10'd649, 10'd768, 10'd707, 10'd741
  };
  localparam logic [ADC_W-1:0] WIN_HI [NUM_WIN] = '{
    10'd213, 10'd253, 10'd300, 10'd350, 10'd412, 10'd492,
    10'd569, 10'd629, 10'd669, 10'd788, 10'd727, 10'd761
  };
  localparam logic [KEY_W-1:0] WIN_KEY [NUM_WIN] = '{
    4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
    4'd7, 4'd8, 4'd9, 4'd0, 4'd10, 4'd11
  };

  typedef enum logic [1:0] {
    DB_IDLE    = 2'd0,
    DB_PRE     = 2'd1,
    DB_HELD    = 2'd2,
    DB_RELEASE = 2'd3
  } db_state_t;

  // Decoded button of one sample.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } key_hit_t;

endpackage

// ----- rtl/core/kdd_in_if.sv -----
// ----------------------------------------------------------------------------
// kdd_in_if
// Sample channel: time stamp, ladder code and ready flag, shift-register bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kdd_in_if;
  import kdd_pkg::*;

  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  time_ms;
  logic [ADC_W-1:0]   adc_code;
  logic               adc_ready;
  logic [SHIFT_W-1:0] shift_bits;

  modport source (
    output valid, time_ms, adc_code, adc_ready, shift_bits,
    input  ready
  );

  modport sink (
    input  valid, time_ms, adc_code, adc_ready, shift_bits,
    output ready
  );
endinterface

// ----- rtl/core/kdd_out_if.sv -----
// ----------------------------------------------------------------------------
// kdd_out_if
// Result channel: press flag and the index of the pressed button.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kdd_out_if;
  import kdd_pkg::*;

  logic             valid;
  logic             ready;
  logic             press_event;
  logic [KEY_W-1:0] button;

  modport source (
    output valid, press_event, button,
    input  ready
  );

  modport sink (
    input  valid, press_event, button,
    output ready
  );
endinterface

// ----- rtl/core/keypad_decode_debounce.sv -----
// ----------------------------------------------------------------------------
// keypad_decode_debounce
// Ladder keypad and shift-register button decoder with press debounce.
// ----------------------------------------------------------------------------
// Use:
//   in_ch  (sink)  : one scan sample per transfer (time, converter code and
//                    ready flag, shift-register bits).
//   out_ch (source): exactly one result per sample: press_event and button;
//                    button is zero unless press_event is set.
//   cfg_we/cfg_wdata: write debounce_ms (hold and release time in ms); write
//                    only while no sample is in flight.
// Path: each sample goes from the input register through decode and debounce
//   into the output register, and its result is valid once that register is
//   loaded; the result transfers out when out_ch.ready is high.
// Throughput: one sample per cycle unless out_ch stalls; decode, the 32-bit
//   elapsed-time compare and the state update form one combinational stage.
// Reset (rst_n low, synchronous): debouncer idle, held button and event time
//   zero, debounce_ms back to 50, both stages empty.
// Stall: while out_ch.ready is low the result holds; one more sample may
//   wait in the input register, after which in_ch.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keypad_decode_debounce (
  input  logic                      clk,
  input  logic                      rst_n,
  kdd_in_if.sink                    in_ch,
  kdd_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [kdd_pkg::DBM_W-1:0] cfg_wdata
);
  import kdd_pkg::*;

  logic               s1_valid_r, s1_valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [TIME_W-1:0]  time_r;
  logic [ADC_W-1:0]   adc_code_r;
  logic               adc_ready_r;
  logic [SHIFT_W-1:0] shift_bits_r;
  logic [DBM_W-1:0]   debounce_ms_r;

  logic     advance;
  logic     step;
  logic     in_xfer;
  key_hit_t hit;

  assign advance     = !out_valid_r || out_ch.ready;
  assign step        = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) s1_valid_nxt = 1'b1;
    else if (advance) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (step) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      debounce_ms_r <= DEBOUNCE_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) debounce_ms_r <= cfg_wdata;
    end
  end

  // input register: capture on each input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      time_r       <= in_ch.time_ms;
      adc_code_r   <= in_ch.adc_code;
      adc_ready_r  <= in_ch.adc_ready;
      shift_bits_r <= in_ch.shift_bits;
    end
  end

  kdd_key_decode u_decode (
    .adc_code_i   (adc_code_r),
    .adc_ready_i  (adc_ready_r),
    .shift_bits_i (shift_bits_r),
    .hit_o        (hit)
  );

  kdd_debounce u_debounce (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_i        (step),
    .hit_i         (hit),
    .time_i        (time_r),
    .debounce_ms_i (debounce_ms_r),
    .press_o       (out_ch.press_event),
    .button_o      (out_ch.button)
  );

  assign out_ch.valid = out_valid_r;

endmodule

// ----- rtl/core/kdd_key_decode.sv -----
// ----------------------------------------------------------------------------
// kdd_key_decode
// Maps one sample to a button: keypad windows first, then a lone shift bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kdd_key_decode (
  input  logic [kdd_pkg::ADC_W-1:0]   adc_code_i,
  input  logic                        adc_ready_i,
  input  logic [kdd_pkg::SHIFT_W-1:0] shift_bits_i,
  output kdd_pkg::key_hit_t           hit_o
);
  import kdd_pkg::*;

  localparam int USED_BYTES = (SHIFT_IN_BYTES < SHIFT_W / 8) ? SHIFT_IN_BYTES : SHIFT_W / 8;

  logic               pad_hit;
  logic [KEY_W-1:0]   pad_key;
  logic [SHIFT_W-1:0] bits_m;
  logic               lone_bit;
  logic [KEY_W-1:0]   bit_key;

  always_comb begin
    pad_hit = 1'b0;
    pad_key = '0;
    for (int i = 0; i < NUM_WIN; i++) begin
      if (adc_ready_i && adc_code_i >= WIN_LO[i] && adc_code_i < WIN_HI[i]) begin
        pad_hit = 1'b1;
        pad_key = WIN_KEY[i];
      end
    end
  end

  // Bit position pos carries button index SHIFT_W-1-pos (MSB of byte 0 is 0).
  always_comb begin
    bits_m  = '0;
    bit_key = '0;
    for (int pos = 0; pos < SHIFT_W; pos++) begin
      if ((SHIFT_W - 1 - pos) < USED_BYTES * 8) begin
        bits_m[pos] = shift_bits_i[pos];
      end
    end
    // exactly one bit set: OR of indices gives that bit's index
    for (int pos = 0; pos < SHIFT_W; pos++) begin
      if (bits_m[pos]) begin
        bit_key = bit_key | KEY_W'(SHIFT_W - 1 - pos);
      end
    end
  end

  assign lone_bit = (bits_m != '0) && ((bits_m & (bits_m - SHIFT_W'(1))) == '0);

  always_comb begin
    if (pad_hit) begin
      hit_o.valid = 1'b1;
      hit_o.key   = pad_key;
    end else begin
      hit_o.valid = lone_bit;
      hit_o.key   = lone_bit ? bit_key : '0;
    end
  end

endmodule

// ----- rtl/core/kdd_debounce.sv -----
// ----------------------------------------------------------------------------
// kdd_debounce
// Four-state press debouncer with the registered result payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module kdd_debounce (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_i,
  input  kdd_pkg::key_hit_t          hit_i,
  input  logic [kdd_pkg::TIME_W-1:0] time_i,
  input  logic [kdd_pkg::DBM_W-1:0]  debounce_ms_i,
  output logic                       press_o,
  output logic [kdd_pkg::KEY_W-1:0]  button_o
);
  import kdd_pkg::*;

  db_state_t         state_r, state_nxt;
  logic [KEY_W-1:0]  held_r, held_nxt;
  logic [TIME_W-1:0] event_time_r, event_time_nxt;
  logic              press_r, press_nxt;
  logic [KEY_W-1:0]  button_r, button_nxt;

  logic              same;
  logic [TIME_W-1:0] elapsed;
  logic              expired;

  assign same    = hit_i.valid && (hit_i.key == held_r);
  assign elapsed = time_i - event_time_r;
  assign expired = elapsed > {{(TIME_W - DBM_W){1'b0}}, debounce_ms_i};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DB_IDLE: begin
        if (hit_i.valid) state_nxt = DB_PRE;
      end
      DB_PRE: begin
        if (!same) state_nxt = DB_IDLE;
        else if (expired) state_nxt = DB_HELD;
      end
      DB_HELD: begin
        if (!same) state_nxt = DB_RELEASE;
      end
      DB_RELEASE: begin
        if (expired) state_nxt = DB_IDLE;
      end
      default: state_nxt = DB_IDLE;
    endcase
  end

  always_comb begin
    held_nxt       = held_r;
    event_time_nxt = event_time_r;
    press_nxt      = 1'b0;
    button_nxt     = '0;
    unique case (state_r)
      DB_IDLE: begin
        if (hit_i.valid) begin
          held_nxt       = hit_i.key;
          event_time_nxt = time_i;
        end
      end
      DB_PRE: begin
        if (same && expired) begin
          press_nxt  = 1'b1;
          button_nxt = held_r;
        end
      end
      DB_HELD: begin
        if (!same) event_time_nxt = time_i;
      end
      DB_RELEASE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= DB_IDLE;
      held_r       <= '0;
      event_time_r <= '0;
    end else if (step_i) begin
      state_r      <= state_nxt;
      held_r       <= held_nxt;
      event_time_r <= event_time_nxt;
    end
  end

  // result payload: loaded with each transfer into the output stage
  always_ff @(posedge clk) begin
    if (step_i) begin
      press_r  <= press_nxt;
      button_r <= button_nxt;
    end
  end

  assign press_o  = press_r;
  assign button_o = button_r;

  `ASSERT_PROP(a_press_enters_held, clk, rst_n, (step_i && press_nxt) |=> (state_r == DB_HELD))
  `ASSERT_PROP(a_no_press_from_idle, clk, rst_n, (step_i && state_r == DB_IDLE) |=> !press_r)
  `ASSERT_PROP(a_no_press_while_held, clk, rst_n, (step_i && state_r == DB_HELD) |=> !press_r)
  `ASSERT_PROP(a_hold_without_step, clk, rst_n,
               !step_i |=> ($stable(state_r) && $stable(held_r) && $stable(event_time_r)))
  `ASSERT_NEVER(a_button_without_press, clk, rst_n, step_i && !press_nxt && button_nxt != '0)

endmodule

// ----- tb/keypad_decode_debounce_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_decode_debounce_tb
// Drives scan samples into the keypad decoder and checks every press result
// against an in-bench model of the ladder windows, the one-hot shift decode
// and the four-state debouncer. Directed samples cover window edges, keypad
// priority, shift bit order and time wrap; random hold/release sequences
// follow at several debounce settings and idle patterns on both channels.
// ----------------------------------------------------------------------------

module keypad_decode_debounce_tb;
  import kdd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_LADDER = 12;

  // Ladder keypad windows [lo, hi) and the key each one selects.
  localparam int LADDER_LO [NUM_LADDER] = '{193, 233, 280, 330, 392, 472,
                                            549, 609, 649, 768, 707, 741};
  localparam int LADDER_HI [NUM_LADDER] = '{213, 253, 300, 350, 412, 492,
                                            569, 629, 669, 788, 727, 761};
  localparam int LADDER_KEY [NUM_LADDER] = '{1, 2, 3, 4, 5, 6,
                                             7, 8, 9, 0, 10, 11};

  typedef struct packed {
    logic             press;
    logic [KEY_W-1:0] button;
  } press_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [DBM_W-1:0] cfg_wdata;

  kdd_in_if  in_if ();
  kdd_out_if out_if ();

  keypad_decode_debounce dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Debouncer model state
  logic [DBM_W-1:0]  hold_limit_ms;
  db_state_t         db_mode;
  logic [KEY_W-1:0]  held_key;
  logic [TIME_W-1:0] event_ms;

  press_t press_q [$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct;
  int recv_stall_pct;
  logic [TIME_W-1:0] cur_ms;

  function automatic logic ladder_lookup(input logic [ADC_W-1:0] code,
                                         output logic [KEY_W-1:0] key);
    logic hit;
    hit = 1'b0;
    key = '0;
    for (int i = 0; i < NUM_LADDER; i++) begin
      if (int'(code) >= LADDER_LO[i] && int'(code) < LADDER_HI[i]) begin
        key = LADDER_KEY[i][KEY_W-1:0];
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic logic decode_key(input logic [ADC_W-1:0] code, input logic rdy,
                                      input logic [SHIFT_W-1:0] bits,
                                      output logic [KEY_W-1:0] key);
    logic hit;
    int ones;
    hit = 1'b0;
    key = '0;
    if (rdy) hit = ladder_lookup(code, key);
    if (!hit) begin
      ones = 0;
      // Bit 15 is button 0, bit 0 is button 15.
      for (int p = 0; p < SHIFT_W; p++) begin
        if (bits[p]) begin
          ones++;
          key = KEY_W'(SHIFT_W - 1 - p);
        end
      end
      hit = (ones == 1);
      if (!hit) key = '0;
    end
    return hit;
  endfunction

  // Advance the debouncer by one sample and queue the result it produces.
  task automatic debounce_sample(input logic [TIME_W-1:0] t_ms, input logic [ADC_W-1:0] code,
                                 input logic rdy, input logic [SHIFT_W-1:0] bits);
    logic [KEY_W-1:0] key;
    logic hit;
    logic same;
    logic [TIME_W-1:0] elapsed;
    press_t res;
    hit = decode_key(code, rdy, bits, key);
    same = hit && (key == held_key);
    elapsed = t_ms - event_ms;
    res = '0;
    case (db_mode)
      DB_IDLE: begin
        if (hit) begin
          held_key = key;
          event_ms = t_ms;
          db_mode = DB_PRE;
        end
      end
      DB_PRE: begin
        if (same) begin
          if (elapsed > {16'd0, hold_limit_ms}) begin
            res.press = 1'b1;
            res.button = held_key;
            db_mode = DB_HELD;
          end
        end else begin
          db_mode = DB_IDLE;
        end
      end
      DB_HELD: begin
        if (!same) begin
          db_mode = DB_RELEASE;
          event_ms = t_ms;
        end
      end
      default: begin
        if (elapsed > {16'd0, hold_limit_ms}) db_mode = DB_IDLE;
      end
    endcase
    press_q.push_back(res);
  endtask

  task automatic send_sample(input logic [TIME_W-1:0] t_ms, input logic [ADC_W-1:0] code,
                             input logic rdy, input logic [SHIFT_W-1:0] bits);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.time_ms    <= t_ms;
    in_if.adc_code   <= code;
    in_if.adc_ready  <= rdy;
    in_if.shift_bits <= bits;
    do @(posedge clk); while (!in_if.ready);
    debounce_sample(t_ms, code, rdy, bits);
  endtask

  // Write debounce_ms once the block has drained.
  task automatic set_hold_time(input logic [DBM_W-1:0] value);
    in_if.valid <= 1'b0;
    while (press_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    hold_limit_ms = value;
  endtask

  function automatic logic [ADC_W-1:0] off_window_code();
    logic [ADC_W-1:0] code;
    logic [KEY_W-1:0] key;
    do code = ADC_W'($urandom); while (ladder_lookup(code, key));
    return code;
  endfunction

  task automatic make_key_sample(input logic [KEY_W-1:0] key, output logic [ADC_W-1:0] code,
                                 output logic rdy, output logic [SHIFT_W-1:0] bits);
    int w;
    if (key <= 4'd11 && $urandom_range(1)) begin
      // Keypad wins over whatever the shift register holds.
      w = 0;
      for (int i = 0; i < NUM_LADDER; i++) if (LADDER_KEY[i] == int'(key)) w = i;
      code = ADC_W'($urandom_range(LADDER_LO[w], LADDER_HI[w] - 1));
      rdy  = 1'b1;
      bits = SHIFT_W'($urandom);
    end else begin
      rdy  = 1'($urandom_range(1));
      code = rdy ? off_window_code() : ADC_W'($urandom);
      bits = SHIFT_W'(1) << (SHIFT_W - 1 - int'(key));
    end
  endtask

  task automatic make_none_sample(output logic [ADC_W-1:0] code, output logic rdy,
                                  output logic [SHIFT_W-1:0] bits);
    rdy  = 1'($urandom_range(1));
    code = rdy ? off_window_code() : ADC_W'($urandom);
    if ($urandom_range(2) == 0) bits = '0;
    else do bits = SHIFT_W'($urandom); while ($countones(bits) == 1);
  endtask

  function automatic logic [TIME_W-1:0] next_step();
    if ($urandom_range(19) == 0) return TIME_W'($urandom_range(0, 200000));
    return TIME_W'($urandom_range(0, int'(hold_limit_ms) / 3 + 1));
  endfunction

  // Result check and receiver stall
  always @(posedge clk) begin
    press_t exp_res;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (press_q.size() == 0) begin
        $display("%0t: unexpected result press_event=%0b button=%0d", $time,
                 out_if.press_event, out_if.button);
        mismatches++;
      end else begin
        exp_res = press_q.pop_front();
        if (out_if.press_event !== exp_res.press) begin
          $display("%0t: press_event expected %0b actual %0b", $time,
                   exp_res.press, out_if.press_event);
          mismatches++;
        end
        if (out_if.button !== exp_res.button) begin
          $display("%0t: button expected %0d actual %0d", $time,
                   exp_res.button, out_if.button);
          mismatches++;
        end
      end
    end
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Keypad priority, hold time boundary, release wait and time wrap.
  task automatic test_time_wrap_and_priority();
    send_sample(32'd100, 10'd0, 1'b1, 16'h0000);
    send_sample(32'hFFFF_FFF0, 10'd200, 1'b1, 16'h8000);
    send_sample(32'h0000_0022, 10'd200, 1'b1, 16'h8000);
    send_sample(32'h0000_0023, 10'd200, 1'b1, 16'h8000);
    send_sample(32'h0000_0030, 10'd200, 1'b1, 16'h0000);
    send_sample(32'h0000_0040, 10'd200, 1'b0, 16'h8000);
    send_sample(32'h0000_0072, 10'd1023, 1'b0, 16'h0000);
    send_sample(32'h0000_0073, 10'd1023, 1'b0, 16'h0000);
  endtask

  // Shift bit order, multi-bit samples and all-ones.
  task automatic test_shift_register_keys();
    send_sample(32'h0000_0080, 10'd1023, 1'b0, 16'h0001);
    send_sample(32'h0000_0090, 10'd1023, 1'b0, 16'h0003);
    send_sample(32'h0000_0100, 10'd0, 1'b1, 16'h0001);
    send_sample(32'hFFFF_FFFF, 10'd0, 1'b1, 16'h0001);
    send_sample(32'hFFFF_FFFF, 10'd1023, 1'b1, 16'hFFFF);
    send_sample(32'h0000_0040, 10'd0, 1'b0, 16'h0000);
  endtask

  // Window bounds are half-open; a different key in pre-press drops to idle.
  task automatic test_window_edges();
    send_sample(32'h0000_0100, 10'd192, 1'b1, 16'h0000);
    send_sample(32'h0000_0101, 10'd213, 1'b1, 16'h0000);
    send_sample(32'h0000_0102, 10'd212, 1'b1, 16'h0000);
    send_sample(32'h0000_0103, 10'd787, 1'b1, 16'h0000);
    send_sample(32'h0000_0104, 10'd768, 1'b1, 16'h0000);
    send_sample(32'h0000_0105, 10'd768, 1'b0, 16'h0100);
    send_sample(32'h0000_0106, 10'd300, 1'b0, 16'h0080);
  endtask

  // Mostly hold/release sequences; some broken holds and raw noise.
  task automatic test_random_presses(input int n_items);
    int sent;
    int kind;
    int guard;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] other;
    logic [ADC_W-1:0] code;
    logic rdy;
    logic [SHIFT_W-1:0] bits;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 8) cur_ms = $urandom();
      key = KEY_W'($urandom);
      if (kind < 70) begin
        guard = 0;
        while (!(db_mode == DB_HELD && held_key == key) && guard < 40) begin
          make_key_sample(key, code, rdy, bits);
          send_sample(cur_ms, code, rdy, bits);
          cur_ms += next_step();
          sent++;
          guard++;
        end
        repeat ($urandom_range(0, 2)) begin
          make_key_sample(key, code, rdy, bits);
          send_sample(cur_ms, code, rdy, bits);
          cur_ms += next_step();
          sent++;
        end
        guard = 0;
        while (db_mode != DB_IDLE && guard < 40) begin
          if ($urandom_range(3) == 0) begin
            do other = KEY_W'($urandom); while (other == key);
            make_key_sample(other, code, rdy, bits);
          end else begin
            make_none_sample(code, rdy, bits);
          end
          send_sample(cur_ms, code, rdy, bits);
          cur_ms += next_step();
          sent++;
          guard++;
        end
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 3)) begin
          make_key_sample(key, code, rdy, bits);
          send_sample(cur_ms, code, rdy, bits);
          cur_ms += next_step();
          sent++;
        end
        if ($urandom_range(1)) begin
          make_none_sample(code, rdy, bits);
        end else begin
          do other = KEY_W'($urandom); while (other == key);
          make_key_sample(other, code, rdy, bits);
        end
        send_sample(cur_ms, code, rdy, bits);
        cur_ms += next_step();
        sent++;
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(3) == 0) cur_ms = $urandom();
          send_sample(cur_ms, ADC_W'($urandom), 1'($urandom), SHIFT_W'($urandom));
          cur_ms += next_step();
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.time_ms    = '0;
    in_if.adc_code   = '0;
    in_if.adc_ready  = 1'b0;
    in_if.shift_bits = '0;
    out_if.ready     = 1'b0;
    send_idle_pct    = 18;
    recv_stall_pct   = 74;
    hold_limit_ms    = DEBOUNCE_RESET;
    db_mode          = DB_IDLE;
    held_key         = '0;
    event_ms         = '0;
    cur_ms           = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_time_wrap_and_priority();
    test_shift_register_keys();
    test_window_edges();
    test_random_presses(200);
    set_hold_time(16'd0);
    test_random_presses(100);

    send_idle_pct  = 74;
    recv_stall_pct = 18;
    set_hold_time(16'hFFFF);
    test_random_presses(120);
    set_hold_time(DBM_W'($urandom_range(1, 200)));
    test_random_presses(100);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_hold_time(16'd3);
    test_random_presses(130);

    in_if.valid <= 1'b0;
    while (press_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && press_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/kdd_pkg.sv
rtl/core/kdd_in_if.sv
rtl/core/kdd_out_if.sv
rtl/core/kdd_key_decode.sv
rtl/core/kdd_debounce.sv
rtl/core/keypad_decode_debounce.sv
tb/keypad_decode_debounce_tb.sv
